// ----- hw/rtl/rpa_pkg.sv -----
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared constants, operation and status codes, and the free-stack control
// types of the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int ADDR_W = 27;   // byte address width
  localparam int OFFS_W = 12;   // 4 KiB page offset
  localparam int PAGE_W = 15;   // page number width
  localparam int OP_W   = 3;
  localparam int STAT_W = 3;
  localparam int REF_W  = 8;    // reported count width
  localparam int ADDR_PAGES = 32768;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INC   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEC   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_MISALIGNED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ZERO       = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NO_PAGES   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_SATURATED  = 3'd5;

  // free-stack request: read of the top, pop, push of one page
  typedef struct packed {
    logic              rd;
    logic              pop;
    logic              push;
    logic [PAGE_W-1:0] page;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

endpackage

// ----- hw/rtl/rpa_count_ram.sv -----
// ----------------------------------------------------------------------------
// rpa_count_ram
// Reference count store: one write port, one registered read port, and a
// clearing sweep after reset that zeroes one entry per cycle.
// ----------------------------------------------------------------------------
module rpa_count_ram #(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic          clearing
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/rpa_free_stack.sv -----
// ----------------------------------------------------------------------------
// rpa_free_stack
// LIFO pool of freed page numbers: a memory plus a depth pointer. The top
// entry is read in the cycle before the pop that consumes it.
// ----------------------------------------------------------------------------
module rpa_free_stack #(
  parameter int DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rpa_pkg::stk_cmd_t         cmd,
  output logic [rpa_pkg::PAGE_W-1:0] top_page,
  output rpa_pkg::stk_stat_t        stat
);

  import rpa_pkg::*;

  localparam int SAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DPW = $clog2(DEPTH + 1);

  logic [PAGE_W-1:0] mem [DEPTH];
  logic [DPW-1:0]    depth;
  logic [DPW-1:0]    depth_m1;

  assign depth_m1   = depth - 1'b1;
  assign stat.empty = (depth == '0);
  assign stat.full  = (depth == DPW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.pop) begin
      depth <= depth_m1;
    end else if (cmd.push) begin
      depth <= depth + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[depth[SAW-1:0]] <= cmd.page;
    end
    if (cmd.rd) begin
      top_page <= mem[depth_m1[SAW-1:0]];
    end
  end

endmodule

// ----- hw/rtl/refcounted_page_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit
// Page frame allocator with a reference count per page and a LIFO pool of
// freed frames; one operation per command, one result per command.
//
//   channel   signals                                   direction
//   command   start, busy, operation, address           in (busy out)
//   result    done, status, page_address, ref_count,    out
//             released
//   config    cfg_valid, cfg_ready, cfg_data            in (ready out)
//
// Each operation passes through S_EXEC: the accept edge reads the count
// store and the stack top, the edge leaving S_EXEC writes back and
// registers the result. done pulses in the cycle after S_EXEC; a new
// command is taken in that same cycle. After reset the count store is
// swept to zero, one page per cycle over min(NUM_PAGES, 32768) pages
// (32768 by default); busy stays high for the sweep and until S_CLEAR ends.
// Results cannot be stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_unit #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rpa_pkg::OP_W-1:0]    operation,
  input  logic [rpa_pkg::ADDR_W-1:0]  address,
  output logic                        done,
  output logic [rpa_pkg::STAT_W-1:0]  status,
  output logic [rpa_pkg::ADDR_W-1:0]  page_address,
  output logic [rpa_pkg::REF_W-1:0]   ref_count,
  output logic                        released,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rpa_pkg::PAGE_W-1:0]  cfg_data
);

  import rpa_pkg::*;

  localparam int LIMIT = (NUM_PAGES > ADDR_PAGES) ? ADDR_PAGES : NUM_PAGES;
  localparam int CAW   = $clog2(LIMIT);
  localparam int FW    = $clog2(LIMIT + 1);
  localparam logic [15:0] LIM16 = 16'(LIMIT);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state;

  logic [PAGE_W-1:0]     first_page;
  logic [OP_W-1:0]       op_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [FW-1:0]         fresh;
  logic [FW-1:0]         fresh_next;
  logic                  accept;
  logic                  clearing;
  logic [PAGE_W-1:0]     page_in;
  logic [PAGE_W-1:0]     page_q;
  logic                  in_lim_in;
  logic                  in_lim_q;
  logic [15:0]           avail16;
  logic [15:0]           fresh_page16;

  logic                  cnt_rd_en;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic                  cnt_wr_en;
  logic [CAW-1:0]        cnt_wr_addr;
  logic [COUNT_BITS-1:0] cnt_wr_data;

  stk_cmd_t              stk_cmd;
  stk_stat_t             stk_stat;
  logic [PAGE_W-1:0]     top_page;
  logic [PAGE_W-1:0]     alloc_page;

  logic [STAT_W-1:0]     res_status;
  logic [ADDR_W-1:0]     res_paddr;
  logic [COUNT_BITS-1:0] res_cnt;
  logic                  res_rel;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign page_in   = address[ADDR_W-1:OFFS_W];
  assign page_q    = addr_q[ADDR_W-1:OFFS_W];
  assign in_lim_in = ({1'b0, page_in} < LIM16);
  assign in_lim_q  = ({1'b0, page_q} < LIM16);
  assign cnt_rd_en = accept && in_lim_in;

  assign avail16      = ({1'b0, first_page} < LIM16) ? (LIM16 - {1'b0, first_page}) : 16'd0;
  assign fresh_page16 = LIM16 - 16'd1 - 16'(fresh);

  rpa_count_ram #(
    .DEPTH (LIMIT),
    .AW    (CAW),
    .DW    (COUNT_BITS)
  ) u_count_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (cnt_rd_en),
    .rd_addr  (page_in[CAW-1:0]),
    .rd_data  (cnt_rd),
    .wr_en    (cnt_wr_en),
    .wr_addr  (cnt_wr_addr),
    .wr_data  (cnt_wr_data),
    .clearing (clearing)
  );

  rpa_free_stack #(
    .DEPTH (NUM_PAGES)
  ) u_free_stack (
    .clk      (clk),
    .rst      (rst),
    .cmd      (stk_cmd),
    .top_page (top_page),
    .stat     (stk_stat)
  );

  // Update logic for the operation held in op_q / addr_q.
  always_comb begin
    cnt_wr_en     = 1'b0;
    cnt_wr_addr   = page_q[CAW-1:0];
    cnt_wr_data   = cnt_rd;
    stk_cmd.rd    = accept && (operation == OP_ALLOC) && !stk_stat.empty;
    stk_cmd.pop   = 1'b0;
    stk_cmd.push  = 1'b0;
    stk_cmd.page  = page_q;
    alloc_page    = top_page;
    fresh_next    = fresh;
    res_status    = STAT_OK;
    res_paddr     = '0;
    res_cnt       = '0;
    res_rel       = 1'b0;
    if (state == S_EXEC) begin
      case (op_q)
        OP_ALLOC: begin
          if (!stk_stat.empty) begin
            stk_cmd.pop = 1'b1;
          end else if (16'(fresh) < avail16) begin
            alloc_page = fresh_page16[PAGE_W-1:0];
            fresh_next = fresh + 1'b1;
          end else begin
            res_status = STAT_NO_PAGES;
          end
          if (res_status == STAT_OK) begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = alloc_page[CAW-1:0];
            cnt_wr_data = COUNT_BITS'(1);
            res_cnt     = COUNT_BITS'(1);
            res_paddr   = {alloc_page, OFFS_W'(0)};
          end
        end
        OP_FREE: begin
          if (!in_lim_q) begin
            res_status = STAT_RANGE;
          end else begin
            res_cnt = cnt_rd;
            if (addr_q[OFFS_W-1:0] != '0) begin
              res_status = STAT_MISALIGNED;
            end else if (page_q < first_page) begin
              res_status = STAT_RANGE;
            end else if (cnt_rd == '0) begin
              res_status = STAT_ZERO;
            end else begin
              res_cnt     = cnt_rd - 1'b1;
              cnt_wr_en   = 1'b1;
              cnt_wr_data = res_cnt;
              if (res_cnt == '0) begin
                res_rel      = 1'b1;
                // drop the push when the pool is full
                stk_cmd.push = !stk_stat.full;
              end
            end
          end
        end
        OP_INC: begin
          if (!in_lim_q) begin
            res_status = STAT_RANGE;
          end else if (cnt_rd == CNT_MAX) begin
            res_status = STAT_SATURATED;
            res_cnt    = cnt_rd;
          end else begin
            res_cnt     = cnt_rd + 1'b1;
            cnt_wr_en   = 1'b1;
            cnt_wr_data = res_cnt;
          end
        end
        OP_DEC: begin
          if (!in_lim_q) begin
            res_status = STAT_RANGE;
          end else if (cnt_rd == '0) begin
            res_status = STAT_ZERO;
          end else begin
            res_cnt     = cnt_rd - 1'b1;
            cnt_wr_en   = 1'b1;
            cnt_wr_data = res_cnt;
          end
        end
        OP_READ: begin
          if (!in_lim_q) begin
            res_status = STAT_RANGE;
          end else begin
            res_cnt = cnt_rd;
          end
        end
        default: begin
          res_status = STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      done       <= 1'b0;
      fresh      <= '0;
      first_page <= '0;
    end else begin
      done  <= (state == S_EXEC);
      fresh <= fresh_next;
      if (cfg_valid && cfg_ready) begin
        first_page <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          if (!clearing) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Hold the command beat and the result beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      addr_q <= address;
    end
    if (state == S_EXEC) begin
      status       <= res_status;
      page_address <= res_paddr;
      ref_count    <= REF_W'(res_cnt);
      released     <= res_rel;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    accept |-> !clearing)
    else $error("command accepted during count sweep");

  a_release_ok: assert property (@(posedge clk) disable iff (rst)
    (done && released) |-> (status == STAT_OK && ref_count == '0))
    else $error("release with bad status or nonzero count");

  a_no_pages_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_NO_PAGES) |-> (page_address == '0 && ref_count == '0))
    else $error("failed allocation reports a page");

  a_alloc_count_one: assert property (@(posedge clk) disable iff (rst)
    (done && page_address != '0) |-> (status == STAT_OK && ref_count == REF_W'(1)))
    else $error("allocated page without count of one");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    (16'(fresh) <= LIM16))
    else $error("fresh page counter past limit");
`endif

endmodule
